FILE: rtl/core/mlp_pkg.sv
package mlp_pkg;

    // Wide working width for exact products and sums before rounding.
    localparam int WIDE_W = 48;

    typedef logic signed [WIDE_W-1:0] wide_t;

    // Sequencer phases of one training step.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HMUL,
        ST_HSUM,
        ST_HSIG,
        ST_OMUL,
        ST_OSUM,
        ST_OSIG,
        ST_DERIV,
        ST_ERR,
        ST_RES,
        ST_UPDO,
        ST_EW,
        ST_HMULU,
        ST_HUPD
    } state_t;

    // Control that the sequencer hands to the lanes and the merging stage.
    typedef struct packed {
        logic        load_en;
        logic [3:0]  load_idx;
        state_t      phase;
    } ctl_t;

    // Clamp to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input wide_t v);
        logic signed [15:0] r;
        if (v > wide_t'(32767))
            r = 16'sh7FFF;
        else if (v < -wide_t'(32768))
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Add one half and take the floor at the binary point.
    function automatic wide_t rnd(input wide_t p, input int frac);
        wide_t h;
        h = wide_t'(1) <<< (frac - 1);
        return (p + h) >>> frac;
    endfunction

    // Piecewise linear sigmoid; the slope terms are truncated.
    function automatic logic [16:0] sigm(input logic signed [15:0] x, input int frac);
        logic [16:0] a;
        int          ai;
        int          one;
        int          y;
        a   = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
        ai  = int'(a);
        one = 1 << frac;
        if (ai >= 5 * one)
            y = one;
        else if (ai >= ((19 * one) >>> 3))
            y = (ai >>> 5) + ((27 * one) >>> 5);
        else if (ai >= one)
            y = (ai >>> 3) + ((5 * one) >>> 3);
        else
            y = (ai >>> 2) + (one >>> 1);
        if (x[15])
            y = one - y;
        return 17'(y);
    endfunction

endpackage

FILE: rtl/core/mlp_lane.sv
module mlp_lane #(
    parameter int NEURON_COUNT  = 2,
    parameter int FRACTION_BITS = 12,
    parameter int LANE          = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mlp_pkg::ctl_t               ctl,
    input  logic signed [15:0]          weight_value,
    input  logic signed [15:0]          x0,
    input  logic signed [15:0]          x1,
    input  logic signed [15:0]          err,
    output logic signed [FRACTION_BITS+17:0] q
);

    localparam int STRIDE = NEURON_COUNT + 1;
    localparam int ONE    = 1 << FRACTION_BITS;

    logic signed [15:0] w0_reg, w0_next;
    logic signed [15:0] w1_reg, w1_next;
    logic signed [15:0] b_reg, b_next;
    logic signed [15:0] wo_reg, wo_next;
    logic signed [31:0] p0_reg, p0_next;
    logic signed [31:0] p1_reg, p1_next;
    logic signed [15:0] s_reg, s_next;
    logic [FRACTION_BITS:0] h_reg, h_next;
    logic [FRACTION_BITS:0] dh_reg, dh_next;
    logic signed [FRACTION_BITS+17:0] q_reg, q_next;
    logic signed [15:0] e_reg, e_next;
    logic signed [15:0] e2_reg, e2_next;
    logic [16:0]        sg;
    logic [7:0]         idx;
    mlp_pkg::wide_t     acc;
    mlp_pkg::wide_t     hw;
    mlp_pkg::wide_t     dw;

    assign idx = {4'b0000, ctl.load_idx};
    assign q   = q_reg;

    // Weights of this lane: loads, then the two update passes.
    always_comb
    begin
        w0_next = w0_reg;
        w1_next = w1_reg;
        b_next  = b_reg;
        wo_next = wo_reg;
        hw      = mlp_pkg::wide_t'($signed({1'b0, h_reg}));
        dw      = mlp_pkg::wide_t'($signed({1'b0, dh_reg}));
        if (ctl.load_en)
        begin
            if (idx == 8'(LANE * STRIDE))
                w0_next = weight_value;
            if (idx == 8'(LANE * STRIDE + 1))
                w1_next = weight_value;
            if (idx == 8'(LANE * STRIDE + NEURON_COUNT))
                b_next = weight_value;
            if (idx == 8'(NEURON_COUNT * STRIDE + LANE))
                wo_next = weight_value;
        end
        if (ctl.phase == mlp_pkg::ST_UPDO)
            wo_next = mlp_pkg::sat16(mlp_pkg::wide_t'(wo_reg)
                + mlp_pkg::rnd(mlp_pkg::wide_t'(err) * hw, FRACTION_BITS));
        if (ctl.phase == mlp_pkg::ST_HUPD)
        begin
            w0_next = mlp_pkg::sat16(mlp_pkg::wide_t'(w0_reg)
                + mlp_pkg::rnd(mlp_pkg::wide_t'(p0_reg), FRACTION_BITS));
            w1_next = mlp_pkg::sat16(mlp_pkg::wide_t'(w1_reg)
                + mlp_pkg::rnd(mlp_pkg::wide_t'(p1_reg), FRACTION_BITS));
            b_next  = mlp_pkg::sat16(mlp_pkg::wide_t'(b_reg) + mlp_pkg::wide_t'(e2_reg));
        end
    end

    // Datapath of the lane, one multiply level per phase.
    always_comb
    begin
        p0_next = p0_reg;
        p1_next = p1_reg;
        s_next  = s_reg;
        h_next  = h_reg;
        dh_next = dh_reg;
        q_next  = q_reg;
        e_next  = e_reg;
        e2_next = e2_reg;
        sg      = mlp_pkg::sigm(s_reg, FRACTION_BITS);
        acc     = (mlp_pkg::wide_t'(b_reg) <<< FRACTION_BITS)
                + mlp_pkg::wide_t'(p0_reg) + mlp_pkg::wide_t'(p1_reg);
        case (ctl.phase)
            mlp_pkg::ST_HMUL:
            begin
                p0_next = x0 * w0_reg;
                p1_next = x1 * w1_reg;
            end
            mlp_pkg::ST_HSUM:
                s_next = mlp_pkg::sat16(mlp_pkg::rnd(acc, FRACTION_BITS));
            mlp_pkg::ST_HSIG:
                h_next = sg[FRACTION_BITS:0];
            mlp_pkg::ST_OMUL:
            begin
                q_next  = $signed({1'b0, h_reg}) * wo_reg;
                dh_next = FRACTION_BITS'(0) + (FRACTION_BITS+1)'(mlp_pkg::rnd(
                    mlp_pkg::wide_t'($signed({1'b0, h_reg}))
                    * mlp_pkg::wide_t'(ONE - int'(h_reg)), FRACTION_BITS));
            end
            mlp_pkg::ST_UPDO:
                e_next = 16'(mlp_pkg::rnd(dw * mlp_pkg::wide_t'(err), FRACTION_BITS));
            mlp_pkg::ST_EW:
                e2_next = mlp_pkg::sat16(mlp_pkg::rnd(
                    mlp_pkg::wide_t'(e_reg) * mlp_pkg::wide_t'(wo_reg), FRACTION_BITS));
            mlp_pkg::ST_HMULU:
            begin
                p0_next = e2_reg * x0;
                p1_next = e2_reg * x1;
            end
            default:
            begin
            end
        endcase
    end

    // Weights reset to zero until loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg <= '0;
            w1_reg <= '0;
            b_reg  <= '0;
            wo_reg <= '0;
        end
        else
        begin
            w0_reg <= w0_next;
            w1_reg <= w1_next;
            b_reg  <= b_next;
            wo_reg <= wo_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        s_reg  <= s_next;
        h_reg  <= h_next;
        dh_reg <= dh_next;
        q_reg  <= q_next;
        e_reg  <= e_next;
        e2_reg <= e2_next;
    end

endmodule

FILE: rtl/core/mlp_merge.sv
module mlp_merge #(
    parameter int NEURON_COUNT  = 2,
    parameter int FRACTION_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mlp_pkg::ctl_t            ctl,
    input  logic signed [15:0]       weight_value,
    input  logic [12:0]              target,
    input  logic signed [NEURON_COUNT-1:0][FRACTION_BITS+17:0] q,
    output logic [FRACTION_BITS:0]   y,
    output logic signed [15:0]       err
);

    localparam int STRIDE = NEURON_COUNT + 1;
    localparam int ONE    = 1 << FRACTION_BITS;

    logic signed [15:0]     bo_reg, bo_next;
    logic signed [15:0]     s_reg, s_next;
    logic [FRACTION_BITS:0] y_reg, y_next;
    logic [FRACTION_BITS:0] d_reg, d_next;
    logic signed [15:0]     err_reg, err_next;
    logic [16:0]            sg;
    mlp_pkg::wide_t         acc;
    mlp_pkg::wide_t         yw;

    assign y   = y_reg;
    assign err = err_reg;

    // Output neuron: bias load, sum of the lane products, sigmoid, derivative, error and bias update.
    always_comb
    begin
        bo_next  = bo_reg;
        s_next   = s_reg;
        y_next   = y_reg;
        d_next   = d_reg;
        err_next = err_reg;
        sg       = mlp_pkg::sigm(s_reg, FRACTION_BITS);
        yw       = mlp_pkg::wide_t'($signed({1'b0, y_reg}));
        acc      = mlp_pkg::wide_t'(bo_reg) <<< FRACTION_BITS;
        for (int i = 0; i < NEURON_COUNT; i++)
            acc = acc + mlp_pkg::wide_t'($signed(q[i]));
        if (ctl.load_en && ({4'b0000, ctl.load_idx} == 8'(NEURON_COUNT * STRIDE + NEURON_COUNT)))
            bo_next = weight_value;
        case (ctl.phase)
            mlp_pkg::ST_OSUM:
                s_next = mlp_pkg::sat16(mlp_pkg::rnd(acc, FRACTION_BITS));
            mlp_pkg::ST_OSIG:
                y_next = sg[FRACTION_BITS:0];
            mlp_pkg::ST_DERIV:
                d_next = (FRACTION_BITS+1)'(mlp_pkg::rnd(
                    yw * (mlp_pkg::wide_t'(ONE) - yw), FRACTION_BITS));
            mlp_pkg::ST_ERR:
                err_next = mlp_pkg::sat16(mlp_pkg::rnd(
                    mlp_pkg::wide_t'($signed({1'b0, d_reg}))
                    * (mlp_pkg::wide_t'({1'b0, target}) - yw), FRACTION_BITS));
            mlp_pkg::ST_UPDO:
                bo_next = mlp_pkg::sat16(mlp_pkg::wide_t'(bo_reg) + mlp_pkg::wide_t'(err_reg));
            default:
            begin
            end
        endcase
    end

    // Output bias resets to zero until loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bo_reg <= '0;
        else
            bo_reg <= bo_next;
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        y_reg   <= y_next;
        d_reg   <= d_next;
        err_reg <= err_next;
    end

endmodule

FILE: rtl/core/mlp_2_2_1_backprop_trainer.sv
// Trainer for a small sigmoid perceptron with NEURON_COUNT hidden neurons, one
// output neuron and Q-format weights with FRACTION_BITS fraction bits, all
// zero after reset. A load item (req_type 0) writes one weight and gives
// no result; slots beyond the weight count are ignored. A train item
// (req_type 1) gives one result item (output, class, output error) and
// then updates every weight with a learning rate of one, so the next item
// sees the new weights. A train item occupies the block, which takes no
// new item meanwhile, for the dependent chain of multiplies, sigmoids and
// updates walked by the sequencer, and longer while the result waits for
// a free output register; the lanes, one per hidden neuron, work in
// parallel with each other.
module mlp_2_2_1_backprop_trainer #(
    parameter int NEURON_COUNT  = 2,
    parameter int FRACTION_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [3:0]         weight_index,
    input  logic signed [15:0] weight_value,
    input  logic signed [15:0] sample_first,
    input  logic signed [15:0] sample_second,
    input  logic [12:0]        target,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [12:0]        net_output,
    output logic               predicted_class,
    output logic signed [15:0] output_error
);

    localparam int ONE = 1 << FRACTION_BITS;

    mlp_pkg::state_t state_reg, state_next;
    mlp_pkg::ctl_t   ctl;

    logic signed [15:0] x0_reg, x1_reg;
    logic [12:0]        tgt_reg;
    logic               out_valid_reg, out_valid_next;
    logic [12:0]        net_output_reg;
    logic               predicted_class_reg;
    logic signed [15:0] output_error_reg;
    logic               out_free;
    logic               res_load;
    logic               take;
    logic [FRACTION_BITS:0] y;
    logic signed [15:0] err;
    logic signed [NEURON_COUNT-1:0][FRACTION_BITS+17:0] q;

    assign take     = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlp_pkg::ST_IDLE:  if (in_valid && req_type) state_next = mlp_pkg::ST_HMUL;
            mlp_pkg::ST_HMUL:  state_next = mlp_pkg::ST_HSUM;
            mlp_pkg::ST_HSUM:  state_next = mlp_pkg::ST_HSIG;
            mlp_pkg::ST_HSIG:  state_next = mlp_pkg::ST_OMUL;
            mlp_pkg::ST_OMUL:  state_next = mlp_pkg::ST_OSUM;
            mlp_pkg::ST_OSUM:  state_next = mlp_pkg::ST_OSIG;
            mlp_pkg::ST_OSIG:  state_next = mlp_pkg::ST_DERIV;
            mlp_pkg::ST_DERIV: state_next = mlp_pkg::ST_ERR;
            mlp_pkg::ST_ERR:   state_next = mlp_pkg::ST_RES;
            mlp_pkg::ST_RES:   if (out_free) state_next = mlp_pkg::ST_UPDO;
            mlp_pkg::ST_UPDO:  state_next = mlp_pkg::ST_EW;
            mlp_pkg::ST_EW:    state_next = mlp_pkg::ST_HMULU;
            mlp_pkg::ST_HMULU: state_next = mlp_pkg::ST_HUPD;
            mlp_pkg::ST_HUPD:  state_next = mlp_pkg::ST_IDLE;
            default:           state_next = mlp_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_stall     = (state_reg != mlp_pkg::ST_IDLE);
        res_load     = (state_reg == mlp_pkg::ST_RES) && out_free;
        ctl.phase    = state_reg;
        ctl.load_en  = (state_reg == mlp_pkg::ST_IDLE) && in_valid && !req_type;
        ctl.load_idx = weight_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mlp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sample held for the whole training step.
    always_ff @(posedge clk)
    begin
        if (take && req_type)
        begin
            x0_reg  <= sample_first;
            x1_reg  <= sample_second;
            tgt_reg <= target;
        end
    end

    // Hidden lanes.
    for (genvar i = 0; i < NEURON_COUNT; i++)
    begin : g_lane
        mlp_lane #(
            .NEURON_COUNT (NEURON_COUNT),
            .FRACTION_BITS(FRACTION_BITS),
            .LANE         (i)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .weight_value(weight_value),
            .x0          (x0_reg),
            .x1          (x1_reg),
            .err         (err),
            .q           (q[i])
        );
    end

    // Output neuron merging the lane products.
    mlp_merge #(
        .NEURON_COUNT (NEURON_COUNT),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .weight_value(weight_value),
        .target      (tgt_reg),
        .q           (q),
        .y           (y),
        .err         (err)
    );

    // Output register; the result item waits here while the update runs.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (res_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            net_output_reg      <= 13'(y);
            predicted_class_reg <= (int'(y) > (ONE >>> 1));
            output_error_reg    <= err;
        end
    end

    assign out_valid       = out_valid_reg;
    assign net_output      = net_output_reg;
    assign predicted_class = predicted_class_reg;
    assign output_error    = output_error_reg;

`ifndef SYNTHESIS
    // A train item starts the forward pass in the next cycle.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        take && req_type |=> state_reg == mlp_pkg::ST_HMUL)
        else $error("train item did not start the forward pass");

    // The sequencer holds the result while the output register is busy.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlp_pkg::ST_RES) && !out_free |=> state_reg == mlp_pkg::ST_RES)
        else $error("result stage left while output register busy");

    // A new result only appears from the result stage.
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == mlp_pkg::ST_RES)
        else $error("output valid rose outside the result stage");
`endif

endmodule

FILE: sim/mlp_trainer_checker.sv
module mlp_trainer_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               req_type,
    input  logic [3:0]         weight_index,
    input  logic signed [15:0] weight_value,
    input  logic signed [15:0] sample_first,
    input  logic signed [15:0] sample_second,
    input  logic [12:0]        target,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [12:0]        net_output,
    input  logic               predicted_class,
    input  logic signed [15:0] output_error,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 12;
    localparam longint ONE_Q = 64'sd1 << FRAC;
    localparam int SLOT_COUNT = 9;
    localparam int OUT_BASE = 6;
    localparam logic LOAD_REQ = 1'b0;

    typedef struct packed {
        logic [12:0]        y;
        logic               cls;
        logic signed [15:0] err;
    } train_result_t;

    logic signed [15:0] weights [SLOT_COUNT];
    train_result_t expected_results [$];

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Round half up at the binary point; arithmetic shift gives the floor.
    function automatic longint round_q(input longint p);
        return (p + (ONE_Q >>> 1)) >>> FRAC;
    endfunction

    function automatic longint sigmoid_q(input longint x);
        longint a;
        longint y;
        a = (x < 0) ? -x : x;
        if (a >= 5 * ONE_Q)
            y = ONE_Q;
        else if (a >= (19 * ONE_Q) / 8)
            y = (a >>> 5) + (27 * ONE_Q) / 32;
        else if (a >= ONE_Q)
            y = (a >>> 3) + (5 * ONE_Q) / 8;
        else
            y = (a >>> 2) + ONE_Q / 2;
        return (x < 0) ? ONE_Q - y : y;
    endfunction

    function automatic longint neuron_out(input int base, input longint x0, input longint x1);
        longint acc;
        acc = longint'(weights[base + 2]) * ONE_Q + x0 * weights[base] + x1 * weights[base + 1];
        return sigmoid_q(clamp16(round_q(acc)));
    endfunction

    task automatic nudge_neuron(input int base, input longint x0, input longint x1,
                                input longint e);
        weights[base]     = 16'(clamp16(weights[base] + round_q(e * x0)));
        weights[base + 1] = 16'(clamp16(weights[base + 1] + round_q(e * x1)));
        weights[base + 2] = 16'(clamp16(weights[base + 2] + e));
    endtask

    // One training step: forward pass, result, then backpropagation.
    task automatic train_step(input longint x0, input longint x1, input longint tgt);
        longint h [2];
        longint y;
        longint err;
        longint e;
        train_result_t r;
        h[0] = neuron_out(0, x0, x1);
        h[1] = neuron_out(3, x0, x1);
        y = neuron_out(OUT_BASE, h[0], h[1]);
        err = clamp16(round_q(round_q(y * (ONE_Q - y)) * (tgt - y)));
        r.y = 13'(y);
        r.cls = (y > ONE_Q / 2);
        r.err = 16'(err);
        expected_results.push_back(r);
        nudge_neuron(OUT_BASE, h[0], h[1], err);
        for (int i = 0; i < 2; i++)
        begin
            e = round_q(round_q(h[i] * (ONE_Q - h[i])) * err);
            e = clamp16(round_q(e * weights[OUT_BASE + i]));
            nudge_neuron(i * 3, x0, x1, e);
        end
    endtask

    assign pending_count = expected_results.size();

    // Track accepted items and compare each result with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        train_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                weights[i] = '0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: net_output %0d", net_output);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (net_output !== exp_r.y)
                    begin
                        $error("net_output: expected %0d, actual %0d", exp_r.y, net_output);
                        fail_count++;
                    end
                    if (predicted_class !== exp_r.cls)
                    begin
                        $error("predicted_class: expected %0d, actual %0d",
                               exp_r.cls, predicted_class);
                        fail_count++;
                    end
                    if (output_error !== exp_r.err)
                    begin
                        $error("output_error: expected %0d, actual %0d",
                               exp_r.err, output_error);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (req_type == LOAD_REQ)
                begin
                    if (weight_index < SLOT_COUNT)
                        weights[weight_index] = weight_value;
                end
                else
                    train_step(sample_first, sample_second, target);
            end
        end
    end
endmodule

FILE: sim/tb_mlp_2_2_1_backprop_trainer.sv
module tb_mlp_2_2_1_backprop_trainer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic LOAD_REQ = 1'b0;
    localparam logic TRAIN_REQ = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic [3:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] sample_first;
    logic signed [15:0] sample_second;
    logic [12:0]        target;
    logic               out_valid;
    logic               out_stall;
    logic [12:0]        net_output;
    logic               predicted_class;
    logic signed [15:0] output_error;
    int                 fail_count;
    int                 pending_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    mlp_2_2_1_backprop_trainer u_top (.*);

    mlp_trainer_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at random at the current rate.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(input logic kind, input logic [3:0] idx,
                             input logic [15:0] val, input logic [15:0] s0,
                             input logic [15:0] s1, input logic [12:0] tgt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= kind;
        weight_index  <= idx;
        weight_value  <= val;
        sample_first  <= s0;
        sample_second <= s1;
        target        <= tgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Mostly small weights keep the net from saturating, so training stays lively.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(16384)) - 8192);
            default: return 16'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    task automatic random_item();
        if ($urandom_range(9) < 2)
            send_item(LOAD_REQ, 4'($urandom_range(15) < 13 ? $urandom_range(8)
                                                           : $urandom_range(15)),
                      pick_value(), 16'($urandom), 16'($urandom), 13'($urandom));
        else
            send_item(TRAIN_REQ, 4'($urandom), 16'($urandom),
                      ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'(($urandom_range(1)) * 4096),
                      ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'(($urandom_range(1)) * 4096),
                      ($urandom_range(4) == 0) ? 13'($urandom)
                                               : 13'($urandom_range(4096)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        req_type = LOAD_REQ;
        weight_index = '0;
        weight_value = '0;
        sample_first = '0;
        sample_second = '0;
        target = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: training on zero weights, extreme loads, extreme samples.
        send_item(TRAIN_REQ, 4'd0, 16'd0, 16'd0, 16'd0, 13'd0);
        for (int i = 0; i < 9; i++)
            send_item(LOAD_REQ, 4'(i), (i % 2) ? 16'h7FFF : 16'h8000, 16'hFFFF, 16'hFFFF,
                      13'h1FFF);
        send_item(LOAD_REQ, 4'd9, 16'h1234, 16'd0, 16'd0, 13'd0);
        send_item(LOAD_REQ, 4'd15, 16'hFFFF, 16'd0, 16'd0, 13'd0);
        send_item(TRAIN_REQ, 4'hF, 16'hFFFF, 16'h7FFF, 16'h8000, 13'd4096);
        send_item(TRAIN_REQ, 4'd0, 16'd0, 16'h8000, 16'h7FFF, 13'd0);
        send_item(TRAIN_REQ, 4'd0, 16'd0, 16'hFFFF, 16'h0001, 13'h1FFF);
        send_item(TRAIN_REQ, 4'd0, 16'd0, 16'd4096, 16'd4096, 13'd0);
        for (int i = 0; i < 9; i++)
            send_item(LOAD_REQ, 4'(i), 16'($signed($urandom_range(4096)) - 2048),
                      16'd0, 16'd0, 13'd0);
        send_item(TRAIN_REQ, 4'd0, 16'd0, 16'd0, 16'd4096, 13'd4096);
        drain();

        // Random phases with varied idling on each side.
        send_idle_pct = 11;
        recv_idle_pct = 88;
        repeat (580) random_item();
        drain();
        send_idle_pct = 88;
        recv_idle_pct = 11;
        repeat (580) random_item();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (590) random_item();
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/mlp_pkg.sv
rtl/core/mlp_lane.sv
rtl/core/mlp_merge.sv
rtl/core/mlp_2_2_1_backprop_trainer.sv
sim/mlp_trainer_checker.sv
sim/tb_mlp_2_2_1_backprop_trainer.sv
